// ===== hw/rtl/qrs_pkg.sv =====
// Shared definitions for the quadratic root solver: default word and fraction
// widths and the result kind codes. Depends on nothing.
package qrs_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_TWO  = 2'd2,
		KIND_ALL  = 2'd3
	} root_kind_t;

endpackage

// ===== hw/rtl/quadratic_root_solver_unit.sv =====
// Top level of the quadratic root solver: magnitudes, products, discriminant,
// bit-serial square root, two division lanes, rounding and an output skid.
// Depends on qrs_pkg and qrs_div_lane.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  request | in_valid, in_ready, coef_a, coef_b, coef_c    | in
//  result  | out_valid, out_ready, root_kind, root_low,    | out
//          | root_high, overflow                           |
//
// One request is taken every cycle while the skid register is empty; in_ready is low otherwise.
// Most of the pipeline is the square root (one root bit per stage,
// WORD_BITS+FRAC_BITS+2 stages) and the division lanes (one quotient bit per stage,
// WORD_BITS+FRAC_BITS+3 stages). Reset clears only the valid bits; no clearing pass.
// When the result is not taken the last result parks in a skid register and the whole
// pipeline then holds; nothing is dropped or repeated.
module quadratic_root_solver_unit #(
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] coef_a,
	input  logic signed [WORD_BITS-1:0] coef_b,
	input  logic signed [WORD_BITS-1:0] coef_c,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  root_kind,
	output logic signed [WORD_BITS-1:0] root_low,
	output logic signed [WORD_BITS-1:0] root_high,
	output logic                        overflow
);
	import qrs_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int RW  = W + F + 2;      // square root width
	localparam int XW  = 2 * RW;         // radicand width
	localparam int NW  = W + F + 4;      // signed numerator width
	localparam int NMW = NW - 1;         // numerator magnitude width
	localparam int DW  = W + 2;          // denominator width
	localparam int PW  = 2 * W;          // product width
	localparam int DDW = 2 * W + 3;      // signed discriminant width
	localparam int SDW = 2 + NW + DW;    // side data through the root stages
	localparam logic [NMW:0] QLIM = (NMW+1)'(1) << (W - 1);

	// global advance: hold every stage ahead of the output register while the skid register is full
	logic en;
	logic sk_v_q;

	assign en       = ~sk_v_q;
	assign in_ready = en;

	// ---------------- stage 1: sign and magnitude ----------------
	logic [W-1:0] a_mag, b_mag, c_mag;

	assign a_mag = coef_a[W-1] ? (~coef_a + 1'b1) : coef_a;
	assign b_mag = coef_b[W-1] ? (~coef_b + 1'b1) : coef_b;
	assign c_mag = coef_c[W-1] ? (~coef_c + 1'b1) : coef_c;

	logic         v_s1;
	logic [W-1:0] am_s1, bm_s1, cm_s1;
	logic         an_s1, bn_s1, cn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1 <= a_mag;
			bm_s1 <= b_mag;
			cm_s1 <= c_mag;
			an_s1 <= coef_a[W-1];
			bn_s1 <= coef_b[W-1];
			cn_s1 <= coef_c[W-1];
		end
	end

	// ---------------- stage 2: products and shared numerator base ----------------
	// Every root is floor(N / D) with N = +-2*M + K (+- the root term) and D = 2*K.
	// Linear case: M = -c << F, K = b. Quadratic case: M = -b << F, K = 2a.
	logic                 a_zero, lin, m_sgn;
	logic [W+F-1:0]       m_mag;
	logic [W:0]           k_mag;
	logic signed [NW-1:0] m2, base_c;

	assign a_zero = ~|am_s1;
	assign lin    = a_zero;
	assign m_mag  = lin ? {cm_s1, {F{1'b0}}} : {bm_s1, {F{1'b0}}};
	assign m_sgn  = lin ? (~cn_s1 ^ bn_s1) : (~bn_s1 ^ an_s1);
	assign k_mag  = lin ? {1'b0, bm_s1} : {am_s1, 1'b0};
	assign m2     = $signed({3'b000, m_mag, 1'b0});
	assign base_c = (m_sgn ? -m2 : m2) + $signed({{(NW-W-1){1'b0}}, k_mag});

	logic                 v_s2;
	logic [PW-1:0]        bb_s2, ac_s2;
	logic                 a_zero_s2, b_zero_s2, c_zero_s2, same_s2;
	logic signed [NW-1:0] base_s2;
	logic [DW-1:0]        den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2     <= bm_s1 * bm_s1;
			ac_s2     <= am_s1 * cm_s1;
			a_zero_s2 <= a_zero;
			b_zero_s2 <= ~|bm_s1;
			c_zero_s2 <= ~|cm_s1;
			same_s2   <= an_s1 ~^ cn_s1;
			base_s2   <= base_c;
			den_s2    <= {k_mag, 1'b0};
		end
	end

	// ---------------- stage 3: discriminant, kind, radicand ----------------
	logic signed [DDW-1:0] bbx, p4, disc;
	root_kind_t            k3;
	logic [XW-1:0]         x0;

	assign bbx  = $signed({3'b000, bb_s2});
	assign p4   = $signed({1'b0, ac_s2, 2'b00});
	assign disc = same_s2 ? (bbx - p4) : (bbx + p4);

	always_comb begin
		priority if (a_zero_s2) begin
			if (!b_zero_s2) begin
				k3 = KIND_ONE;
			end else if (c_zero_s2) begin
				k3 = KIND_ALL;
			end else begin
				k3 = KIND_NONE;
			end
		end else if (disc[DDW-1]) begin
			k3 = KIND_NONE;
		end else if (disc == '0) begin
			k3 = KIND_ONE;
		end else begin
			k3 = KIND_TWO;
		end
	end

	// scale so the root comes out as 2^(F+1) * sqrt(disc); zero unless two roots
	assign x0 = (k3 == KIND_TWO) ? {disc[DDW-2:0], {(2*F+2){1'b0}}} : '0;

	logic            sq_v    [0:RW];
	logic [XW-1:0]   sq_x    [0:RW];
	logic [RW+1:0]   sq_rem  [0:RW];
	logic [RW-1:0]   sq_root [0:RW];
	logic [SDW-1:0]  sq_side [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x[0]    <= x0;
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_side[0] <= {k3, base_s2, den_s2};
		end
	end

	// ---------------- square root: one result bit per stage ----------------
	for (genvar k = 1; k <= RW; k++) begin : g_sqrt
		logic [RW+1:0] rsh, trial;
		logic          ge;

		assign rsh   = {sq_rem[k-1][RW-1:0], sq_x[k-1][XW-1 -: 2]};
		assign trial = {sq_root[k-1], 2'b01};
		assign ge    = (rsh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k] <= 1'b0;
			end else if (en) begin
				sq_v[k] <= sq_v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_x[k]    <= sq_x[k-1] << 2;
				sq_rem[k]  <= ge ? (rsh - trial) : rsh;
				sq_root[k] <= {sq_root[k-1][RW-2:0], ge};
				sq_side[k] <= sq_side[k-1];
			end
		end
	end

	// ---------------- stage 4: both numerators ----------------
	// upper root uses the floor of the scaled root, lower root its ceiling
	root_kind_t           kind4;
	logic signed [NW-1:0] base4, rx, ex;
	logic [DW-1:0]        den4;

	assign kind4 = root_kind_t'(sq_side[RW][SDW-1 -: 2]);
	assign base4 = $signed(sq_side[RW][DW +: NW]);
	assign den4  = sq_side[RW][DW-1:0];
	assign rx    = $signed({{(NW-RW){1'b0}}, sq_root[RW]});
	assign ex    = $signed({{(NW-1){1'b0}}, |sq_rem[RW]});

	logic                 v_s4;
	logic signed [NW-1:0] nlo_s4, nhi_s4;
	root_kind_t           kind_s4;
	logic [DW-1:0]        den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nlo_s4  <= base4 - rx - ex;
			nhi_s4  <= base4 + rx;
			kind_s4 <= kind4;
			den_s4  <= den4;
		end
	end

	// ---------------- stage 5: sign and magnitude of numerators ----------------
	logic [NW-1:0] nlo_abs, nhi_abs;

	assign nlo_abs = nlo_s4[NW-1] ? -nlo_s4 : nlo_s4;
	assign nhi_abs = nhi_s4[NW-1] ? -nhi_s4 : nhi_s4;

	logic           v_s5;
	logic [NMW-1:0] lo_mag_s5, hi_mag_s5;
	logic           lo_neg_s5, hi_neg_s5;
	root_kind_t     kind_s5;
	logic [DW-1:0]  den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_mag_s5 <= nlo_abs[NMW-1:0];
			hi_mag_s5 <= nhi_abs[NMW-1:0];
			lo_neg_s5 <= nlo_s4[NW-1];
			hi_neg_s5 <= nhi_s4[NW-1];
			kind_s5   <= kind_s4;
			den_s5    <= den_s4;
		end
	end

	// ---------------- division lanes ----------------
	logic           lo_v, hi_v, lo_nz, hi_nz;
	logic [NMW-1:0] lo_q, hi_q;
	logic [2:0]     lo_side;
	logic           hi_side;

	qrs_div_lane #(
		.NUM_W  (NMW),
		.DEN_W  (DW),
		.SIDE_W (3)
	) u_lane_lo (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s5),
		.in_num     (lo_mag_s5),
		.in_den     (den_s5),
		.in_side    ({kind_s5, lo_neg_s5}),
		.out_valid  (lo_v),
		.out_quo    (lo_q),
		.out_rem_nz (lo_nz),
		.out_side   (lo_side)
	);

	qrs_div_lane #(
		.NUM_W  (NMW),
		.DEN_W  (DW),
		.SIDE_W (1)
	) u_lane_hi (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s5),
		.in_num     (hi_mag_s5),
		.in_den     (den_s5),
		.in_side    (hi_neg_s5),
		.out_valid  (hi_v),
		.out_quo    (hi_q),
		.out_rem_nz (hi_nz),
		.out_side   (hi_side)
	);

	// ---------------- stage 6: floor for negative numerators ----------------
	logic           v_s6;
	logic [NMW:0]   qlo_s6, qhi_s6;
	logic           nlo_s6, nhi_s6;
	root_kind_t     kind_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= lo_v & hi_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qlo_s6  <= {1'b0, lo_q} + (NMW+1)'(lo_side[0] & lo_nz);
			qhi_s6  <= {1'b0, hi_q} + (NMW+1)'(hi_side & hi_nz);
			nlo_s6  <= lo_side[0];
			nhi_s6  <= hi_side;
			kind_s6 <= root_kind_t'(lo_side[2:1]);
		end
	end

	// saturate to the word range, apply the sign, blank absent roots
	logic         lo_ovf, hi_ovf;
	logic [W-1:0] lo_val, hi_val;
	logic [W-1:0] f_low, f_high;
	logic         f_ovf;
	root_kind_t   f_kind;

	assign lo_ovf = nlo_s6 ? (qlo_s6 > QLIM) : (qlo_s6 >= QLIM);
	assign hi_ovf = nhi_s6 ? (qhi_s6 > QLIM) : (qhi_s6 >= QLIM);

	always_comb begin
		if (nlo_s6) begin
			lo_val = lo_ovf ? {1'b1, {(W-1){1'b0}}} : (~qlo_s6[W-1:0] + 1'b1);
		end else begin
			lo_val = lo_ovf ? {1'b0, {(W-1){1'b1}}} : qlo_s6[W-1:0];
		end
		if (nhi_s6) begin
			hi_val = hi_ovf ? {1'b1, {(W-1){1'b0}}} : (~qhi_s6[W-1:0] + 1'b1);
		end else begin
			hi_val = hi_ovf ? {1'b0, {(W-1){1'b1}}} : qhi_s6[W-1:0];
		end
		f_kind = kind_s6;
		unique case (kind_s6)
			KIND_ONE: begin
				f_low  = lo_val;
				f_high = '0;
				f_ovf  = lo_ovf;
			end
			KIND_TWO: begin
				f_low  = lo_val;
				f_high = hi_val;
				f_ovf  = lo_ovf | hi_ovf;
			end
			default: begin
				f_low  = '0;
				f_high = '0;
				f_ovf  = 1'b0;
			end
		endcase
	end

	// ---------------- output register and skid ----------------
	logic         up_fire;
	logic         out_v_q;
	root_kind_t   out_kind_q, sk_kind_q;
	logic [W-1:0] out_low_q, out_high_q, sk_low_q, sk_high_q;
	logic         out_ovf_q, sk_ovf_q;

	assign up_fire = v_s6 & en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end else begin
				out_v_q <= up_fire;
			end
		end else if (up_fire) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (sk_v_q) begin
				out_kind_q <= sk_kind_q;
				out_low_q  <= sk_low_q;
				out_high_q <= sk_high_q;
				out_ovf_q  <= sk_ovf_q;
			end else begin
				out_kind_q <= f_kind;
				out_low_q  <= f_low;
				out_high_q <= f_high;
				out_ovf_q  <= f_ovf;
			end
		end else if (up_fire) begin
			sk_kind_q <= f_kind;
			sk_low_q  <= f_low;
			sk_high_q <= f_high;
			sk_ovf_q  <= f_ovf;
		end
	end

	assign out_valid = out_v_q;
	assign root_kind = out_kind_q;
	assign root_low  = out_low_q;
	assign root_high = out_high_q;
	assign overflow  = out_ovf_q;

endmodule

// ===== hw/rtl/qrs_div_lane.sv =====
// Restoring long-division pipeline, one quotient bit per stage, for the root solver.
// Stand-alone; instantiated twice by quadratic_root_solver_unit.
module qrs_div_lane #(
	parameter int NUM_W  = 51,
	parameter int DEN_W  = 34,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic              out_rem_nz,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [1:NUM_W];
	logic [NUM_W-1:0]  num_s  [1:NUM_W];
	logic [NUM_W-1:0]  quo_s  [1:NUM_W];
	logic [DEN_W-1:0]  rem_s  [1:NUM_W];
	logic [DEN_W-1:0]  den_s  [1:NUM_W];
	logic [SIDE_W-1:0] side_s [1:NUM_W];

	for (genvar k = 1; k <= NUM_W; k++) begin : g_step
		logic              pv;
		logic [NUM_W-1:0]  pn;
		logic [NUM_W-1:0]  pq;
		logic [DEN_W-1:0]  pr;
		logic [DEN_W-1:0]  pd;
		logic [SIDE_W-1:0] ps;
		logic [DEN_W:0]    rsh;
		logic [DEN_W:0]    rdif;
		logic              ge;

		if (k == 1) begin : g_first
			assign pv = in_valid;
			assign pn = in_num;
			assign pq = '0;
			assign pr = '0;
			assign pd = in_den;
			assign ps = in_side;
		end else begin : g_next
			assign pv = vld_s[k-1];
			assign pn = num_s[k-1];
			assign pq = quo_s[k-1];
			assign pr = rem_s[k-1];
			assign pd = den_s[k-1];
			assign ps = side_s[k-1];
		end

		// bring down the next dividend bit and try the divisor
		assign rsh  = {pr, pn[NUM_W-1]};
		assign rdif = rsh - {1'b0, pd};
		assign ge   = (rsh >= {1'b0, pd});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k]  <= pn << 1;
				quo_s[k]  <= {pq[NUM_W-2:0], ge};
				rem_s[k]  <= ge ? rdif[DEN_W-1:0] : rsh[DEN_W-1:0];
				den_s[k]  <= pd;
				side_s[k] <= ps;
			end
		end
	end

	assign out_valid  = vld_s[NUM_W];
	assign out_quo    = quo_s[NUM_W];
	assign out_rem_nz = |rem_s[NUM_W];
	assign out_side   = side_s[NUM_W];

endmodule

// ===== hw/rtl/qrs_checker.sv =====
// Port-level checks for quadratic_root_solver_unit, with the bind that attaches them.
// Depends on qrs_pkg.
module qrs_checker #(
	parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  root_kind,
	input logic signed [WORD_BITS-1:0] root_low,
	input logic signed [WORD_BITS-1:0] root_high,
	input logic                        overflow
);
	import qrs_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root_kind) && $stable(root_low)
			&& $stable(root_high) && $stable(overflow))
		else $error("result changed while stalled");

	a_no_roots_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_kind == KIND_NONE || root_kind == KIND_ALL)
			|-> root_low == '0 && root_high == '0 && !overflow)
		else $error("roots reported without a root");

	a_one_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_ONE |-> root_high == '0)
		else $error("upper root set for a single root");

	a_two_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_TWO |-> root_low <= root_high)
		else $error("roots out of order");

endmodule

bind quadratic_root_solver_unit qrs_checker #(.WORD_BITS(WORD_BITS)) u_qrs_checker (.*);
